FILE: hdl/afc_pkg.sv
package afc_pkg;

  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned COEF_BITS_DEF  = 16;
  localparam int unsigned FRAC_BITS      = 12;

  localparam int unsigned NUM_ROWS    = 4;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned CODE_W      = 6;

  localparam int unsigned COEF_LANE_W = 16;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 3;

  // 1.0 in Q4.12, the diagonal of the reset matrix
  localparam logic [COEF_LANE_W-1:0] ONE_LANE = 16'h1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0 = 3'd0,
    CFG_ROW1 = 3'd1,
    CFG_ROW2 = 3'd2,
    CFG_ROW3 = 3'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VIS_OUTSIDE = 2'd0,
    VIS_PARTIAL = 2'd1,
    VIS_INSIDE  = 2'd2
  } vis_e;

  typedef logic [CODE_W-1:0] outcode_t;

  typedef struct packed {
    logic en_sum;
    logic en_code;
  } lane_ctrl_t;

endpackage

FILE: hdl/aabb_frustum_clip_test_core.sv
// Box-against-frustum culling by corner outcodes.
// Input channel: in_valid_i / in_stall_o with the box corners min_*_i and
// max_*_i (signed fixed point, 12 fraction bits). A transaction takes place
// on a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with visibility_o (0 outside,
// 1 partial, 2 inside) and the OR / AND of the eight corner outcodes.
// Configuration: cfg_we_i writes cfg_data_i to matrix row cfg_idx_i (0..3);
// other indexes are ignored. Write only while the pipeline is empty.
// Throughput is one box per cycle while out_stall_i stays low. From input
// transaction to out_valid_o a box passes these registered stages in order:
// shared coefficient products, per-corner sums in eight parallel lanes,
// per-corner outcodes, then the merge into the output register.
// Reset clears all stage valids and loads the identity matrix.
// When the receiver stalls, results hold and bubbles are squeezed out; the
// input stalls only once every stage holds a result.
module aabb_frustum_clip_test_core #(
  parameter int unsigned COORD_BITS = afc_pkg::COORD_BITS_DEF,
  parameter int unsigned COEF_BITS  = afc_pkg::COEF_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [afc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [afc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [COORD_BITS-1:0]     min_x_i,
  input  logic signed [COORD_BITS-1:0]     min_y_i,
  input  logic signed [COORD_BITS-1:0]     min_z_i,
  input  logic signed [COORD_BITS-1:0]     max_x_i,
  input  logic signed [COORD_BITS-1:0]     max_y_i,
  input  logic signed [COORD_BITS-1:0]     max_z_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       visibility_o,
  output logic [afc_pkg::CODE_W-1:0]       outcode_union_o,
  output logic [afc_pkg::CODE_W-1:0]       outcode_common_o
);
  import afc_pkg::*;

  localparam int unsigned PROD_W     = COORD_BITS + COEF_BITS;
  localparam int unsigned NUM_STAGES = 4;

  logic signed [COEF_BITS-1:0] coef_q [NUM_ROWS][NUM_ROWS];
  logic [NUM_ROWS-1:0]         row_we;

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] adv;

  logic signed [COORD_BITS-1:0] lo [NUM_AXES];
  logic signed [COORD_BITS-1:0] hi [NUM_AXES];
  logic signed [PROD_W-1:0]     p_lo   [NUM_ROWS][NUM_AXES];
  logic signed [PROD_W-1:0]     p_hi   [NUM_ROWS][NUM_AXES];
  logic signed [PROD_W-1:0]     w_term [NUM_ROWS];
  outcode_t                     codes  [NUM_CORNERS];
  lane_ctrl_t                   lane_ctrl;
  vis_e                         vis;

  // Matrix rows
  always_comb begin
    row_we = '0;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ROW0: row_we[0] = 1'b1;
        CFG_ROW1: row_we[1] = 1'b1;
        CFG_ROW2: row_we[2] = 1'b1;
        CFG_ROW3: row_we[3] = 1'b1;
        default:  row_we    = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        for (int j = 0; j < NUM_ROWS; j++) begin
          coef_q[i][j] <= (i == j) ? ONE_LANE[COEF_BITS-1:0] : '0;
        end
      end
    end else begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        if (row_we[i]) begin
          for (int j = 0; j < NUM_ROWS; j++) begin
            coef_q[i][j] <= cfg_data_i[COEF_LANE_W*j +: COEF_BITS];
          end
        end
      end
    end
  end

  // Pipeline control: a stage moves on when it is empty or the next one moves
  always_comb begin
    adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall_i;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (adv[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  assign lo[0] = min_x_i;
  assign lo[1] = min_y_i;
  assign lo[2] = min_z_i;
  assign hi[0] = max_x_i;
  assign hi[1] = max_y_i;
  assign hi[2] = max_z_i;

  afc_product #(
    .COORD_BITS(COORD_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_product (
    .clk_i   (clk_i),
    .en_i    (adv[0]),
    .lo_i    (lo),
    .hi_i    (hi),
    .coef_i  (coef_q),
    .p_lo_o  (p_lo),
    .p_hi_o  (p_hi),
    .w_term_o(w_term)
  );

  assign lane_ctrl.en_sum  = adv[1];
  assign lane_ctrl.en_code = adv[2];

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_lane
    afc_lane #(
      .COORD_BITS(COORD_BITS),
      .COEF_BITS (COEF_BITS),
      .CORNER    (k)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .p_lo_i   (p_lo),
      .p_hi_i   (p_hi),
      .w_term_i (w_term),
      .outcode_o(codes[k])
    );
  end

  afc_merge u_merge (
    .clk_i       (clk_i),
    .en_i        (adv[3]),
    .code_i      (codes),
    .visibility_o(vis),
    .union_o     (outcode_union_o),
    .common_o    (outcode_common_o)
  );

  assign visibility_o = vis;

endmodule

FILE: hdl/afc_product.sv
module afc_product #(
  parameter int unsigned COORD_BITS = afc_pkg::COORD_BITS_DEF,
  parameter int unsigned COEF_BITS  = afc_pkg::COEF_BITS_DEF,
  localparam int unsigned PROD_W    = COORD_BITS + COEF_BITS
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] lo_i     [afc_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0] hi_i     [afc_pkg::NUM_AXES],
  input  logic signed [COEF_BITS-1:0]  coef_i   [afc_pkg::NUM_ROWS][afc_pkg::NUM_ROWS],
  output logic signed [PROD_W-1:0]     p_lo_o   [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES],
  output logic signed [PROD_W-1:0]     p_hi_o   [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES],
  output logic signed [PROD_W-1:0]     w_term_o [afc_pkg::NUM_ROWS]
);
  import afc_pkg::*;

  logic signed [PROD_W-1:0] p_lo_q [NUM_ROWS][NUM_AXES];
  logic signed [PROD_W-1:0] p_hi_q [NUM_ROWS][NUM_AXES];
  logic signed [PROD_W-1:0] w_q    [NUM_ROWS];

  // Each row/axis product is shared by the four corners that use it
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          p_lo_q[i][j] <= coef_i[i][j] * lo_i[j];
          p_hi_q[i][j] <= coef_i[i][j] * hi_i[j];
        end
        // w is 1.0, so the last column only needs aligning
        w_q[i] <= PROD_W'(coef_i[i][NUM_ROWS-1]) <<< FRAC_BITS;
      end
    end
  end

  assign p_lo_o   = p_lo_q;
  assign p_hi_o   = p_hi_q;
  assign w_term_o = w_q;

endmodule

FILE: hdl/afc_lane.sv
module afc_lane #(
  parameter int unsigned COORD_BITS = afc_pkg::COORD_BITS_DEF,
  parameter int unsigned COEF_BITS  = afc_pkg::COEF_BITS_DEF,
  parameter int unsigned CORNER     = 0,
  localparam int unsigned PROD_W    = COORD_BITS + COEF_BITS
) (
  input  logic                     clk_i,
  input  afc_pkg::lane_ctrl_t      ctrl_i,
  input  logic signed [PROD_W-1:0] p_lo_i   [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES],
  input  logic signed [PROD_W-1:0] p_hi_i   [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES],
  input  logic signed [PROD_W-1:0] w_term_i [afc_pkg::NUM_ROWS],
  output afc_pkg::outcode_t        outcode_o
);
  import afc_pkg::*;

  localparam int unsigned SUM_W = PROD_W + 2;
  // bit j picks the max corner on axis j
  localparam logic [NUM_AXES-1:0] SEL = NUM_AXES'(CORNER);

  logic signed [SUM_W-1:0] clip_d [NUM_ROWS];
  logic signed [SUM_W-1:0] clip_q [NUM_ROWS];
  logic [SUM_W:0]          neg_chk [NUM_AXES];
  outcode_t                code_d, code_q;

  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      clip_d[i] = SUM_W'(w_term_i[i]);
      for (int j = 0; j < NUM_AXES; j++) begin
        clip_d[i] = clip_d[i] + SUM_W'(SEL[j] ? p_hi_i[i][j] : p_lo_i[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_sum) begin
      clip_q <= clip_d;
    end
  end

  // c < -w tested as c + w < 0, one bit wider so it cannot wrap
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      neg_chk[a] = {clip_q[a][SUM_W-1], clip_q[a]}
                 + {clip_q[NUM_ROWS-1][SUM_W-1], clip_q[NUM_ROWS-1]};
      code_d[2*a]   = clip_q[a] > clip_q[NUM_ROWS-1];
      code_d[2*a+1] = neg_chk[a][SUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_code) begin
      code_q <= code_d;
    end
  end

  assign outcode_o = code_q;

endmodule

FILE: hdl/afc_merge.sv
module afc_merge (
  input  logic              clk_i,
  input  logic              en_i,
  input  afc_pkg::outcode_t code_i [afc_pkg::NUM_CORNERS],
  output afc_pkg::vis_e     visibility_o,
  output afc_pkg::outcode_t union_o,
  output afc_pkg::outcode_t common_o
);
  import afc_pkg::*;

  outcode_t uni_d, com_d;
  vis_e     vis_d;
  outcode_t uni_q, com_q;
  vis_e     vis_q;

  always_comb begin
    uni_d = '0;
    com_d = '1;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      uni_d = uni_d | code_i[k];
      com_d = com_d & code_i[k];
    end
    if (com_d != '0) begin
      vis_d = VIS_OUTSIDE;
    end else if (uni_d == '0) begin
      vis_d = VIS_INSIDE;
    end else begin
      vis_d = VIS_PARTIAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uni_q <= uni_d;
      com_q <= com_d;
      vis_q <= vis_d;
    end
  end

  assign visibility_o = vis_q;
  assign union_o      = uni_q;
  assign common_o     = com_q;

endmodule
